// ----- rtl/ntab_pkg.sv -----
`timescale 1ns / 1ps

package ntab_pkg;

    // Table geometry
    localparam int SLOTS    = 32;
    localparam int AW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int NTH_W    = 5;
    localparam int SEEN_RAW = $clog2(SLOTS + 1);
    localparam int SEEN_W   = (SEEN_RAW > NTH_W) ? SEEN_RAW : NTH_W;
    localparam int CNT_W    = 6;

    localparam logic [31:0] RESET_TIMEOUT = 32'd5000;

    // Request modes
    localparam logic [2:0] MODE_UPDATE = 3'd0;
    localparam logic [2:0] MODE_SWEEP  = 3'd1;
    localparam logic [2:0] MODE_NTH    = 3'd2;
    localparam logic [2:0] MODE_FIND   = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_UPDATED   = 3'd0;
    localparam logic [2:0] ST_INSERTED  = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_SWEPT     = 3'd5;
    localparam logic [2:0] ST_CLEARED   = 3'd6;

    typedef struct packed {
        logic [2:0]       mode;
        logic [7:0]       source_address;
        logic [15:0]      group_number;
        logic [31:0]      time_ms;
        logic [63:0]      payload;
        logic             payload_present;
        logic [NTH_W-1:0] entry_index;
    } t_req;

    typedef struct packed {
        logic [2:0]       status;
        logic [7:0]       found_source_address;
        logic [15:0]      found_group_number;
        logic [31:0]      found_time_ms;
        logic [63:0]      found_payload;
        logic [CNT_W-1:0] live_count;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic load;   // latch request, reset scan state
        logic issue;  // read slot at scan address, advance
        logic fin;    // commit write-back and present result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic addr_last;
    } t_sts;

endpackage

// ----- rtl/ntab_ctrl.sv -----
`timescale 1ns / 1ps

module ntab_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [2:0]        i_mode,
    input  ntab_pkg::t_sts    i_sts,
    output ntab_pkg::t_cmd    o_cmd,
    output logic              o_busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_mode) inside
                        ntab_pkg::MODE_UPDATE, ntab_pkg::MODE_SWEEP,
                        ntab_pkg::MODE_NTH, ntab_pkg::MODE_FIND: begin
                            n_state = S_SCAN;
                            n_busy  = 1'b1;
                        end
                        ntab_pkg::MODE_CLEAR: begin
                            n_state = S_COMMIT;
                            n_busy  = 1'b1;
                        end
                        default: begin
                            // unused mode: dropped, no result
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (i_sts.addr_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    assign o_cmd.load  = (r_state == S_IDLE) && i_start;
    assign o_cmd.issue = (r_state == S_SCAN);
    assign o_cmd.fin   = (r_state == S_COMMIT);
    assign o_busy      = r_busy;

endmodule

// ----- rtl/ntab_dp.sv -----
`timescale 1ns / 1ps

module ntab_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ntab_pkg::t_cmd    i_cmd,
    output ntab_pkg::t_sts    o_sts,
    input  ntab_pkg::t_req    i_req,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    output logic              o_done,
    output ntab_pkg::t_rsp    o_rsp
);

    // Slot storage (contents defined only once written)
    logic [23:0] mem_key  [ntab_pkg::SLOTS];
    logic [31:0] mem_time [ntab_pkg::SLOTS];
    logic [63:0] mem_pay  [ntab_pkg::SLOTS];

    ntab_pkg::t_req                r_req;
    logic [31:0]                   r_limit;
    logic [ntab_pkg::SLOTS-1:0]    r_valid, n_valid;
    logic [ntab_pkg::CNT_W-1:0]    r_count, n_count;
    logic [ntab_pkg::AW-1:0]       r_addr;

    // read stage
    logic                          r_rd_vld;
    logic [ntab_pkg::AW-1:0]       r_rd_idx;
    logic                          r_rd_valid;
    logic [23:0]                   r_rd_key;
    logic [31:0]                   r_rd_time;
    logic [63:0]                   r_rd_pay;

    // scan results
    logic                          r_hit;
    logic [ntab_pkg::AW-1:0]       r_hit_idx;
    logic [23:0]                   r_hit_key;
    logic [31:0]                   r_hit_time;
    logic [63:0]                   r_hit_pay;
    logic                          r_free;
    logic [ntab_pkg::AW-1:0]       r_free_idx;
    logic [ntab_pkg::SEEN_W-1:0]   r_seen;

    logic                          r_done;
    ntab_pkg::t_rsp                r_rsp, n_rsp;

    logic                          e_valid, e_key_eq, e_grp_eq, e_aged, e_take, e_free;
    logic [31:0]                   e_elapsed;
    logic                          c_we_key, c_we_time, c_we_pay, c_set_valid, c_clear;
    logic [ntab_pkg::AW-1:0]       c_widx;
    logic [63:0]                   c_wpay;

    assign o_sts.addr_last = (r_addr == ntab_pkg::AW'(ntab_pkg::SLOTS - 1));

    // per-slot evaluation
    always_comb begin
        e_valid   = r_rd_vld && r_rd_valid;
        e_key_eq  = (r_rd_key == {r_req.source_address, r_req.group_number});
        e_grp_eq  = (r_rd_key[15:0] == r_req.group_number);
        e_elapsed = r_req.time_ms - r_rd_time;
        e_aged    = e_valid && (r_req.mode == ntab_pkg::MODE_SWEEP) && (e_elapsed > r_limit);
        e_take    = !r_hit && e_valid &&
                    (((r_req.mode == ntab_pkg::MODE_UPDATE) && e_key_eq) ||
                     ((r_req.mode == ntab_pkg::MODE_FIND) && e_grp_eq) ||
                     ((r_req.mode == ntab_pkg::MODE_NTH) &&
                      (r_seen == ntab_pkg::SEEN_W'(r_req.entry_index))));
        e_free    = r_rd_vld && !r_rd_valid && !r_free &&
                    (r_req.mode == ntab_pkg::MODE_UPDATE);
    end

    // commit decode; no slot is aged during commit, so the count moves only
    // by an insert or a clear here
    always_comb begin
        c_we_key    = 1'b0;
        c_we_time   = 1'b0;
        c_we_pay    = 1'b0;
        c_set_valid = 1'b0;
        c_clear     = 1'b0;
        c_widx      = r_hit ? r_hit_idx : r_free_idx;
        c_wpay      = r_req.payload_present ? r_req.payload : 64'd0;
        n_rsp            = '0;
        n_rsp.live_count = r_count;
        unique case (r_req.mode)
            ntab_pkg::MODE_UPDATE: begin
                if (r_hit) begin
                    c_we_time                  = i_cmd.fin;
                    c_we_pay                   = i_cmd.fin && r_req.payload_present;
                    n_rsp.status               = ntab_pkg::ST_UPDATED;
                    n_rsp.found_source_address = r_hit_key[23:16];
                    n_rsp.found_group_number   = r_hit_key[15:0];
                    n_rsp.found_time_ms        = r_req.time_ms;
                    n_rsp.found_payload        = r_req.payload_present ? r_req.payload
                                                                       : r_hit_pay;
                end else if (r_free) begin
                    c_we_key                   = i_cmd.fin;
                    c_we_time                  = i_cmd.fin;
                    c_we_pay                   = i_cmd.fin;
                    c_set_valid                = i_cmd.fin;
                    n_rsp.status               = ntab_pkg::ST_INSERTED;
                    n_rsp.found_source_address = r_req.source_address;
                    n_rsp.found_group_number   = r_req.group_number;
                    n_rsp.found_time_ms        = r_req.time_ms;
                    n_rsp.found_payload        = c_wpay;
                    n_rsp.live_count           = r_count + 1'b1;
                end else begin
                    n_rsp.status = ntab_pkg::ST_FULL;
                end
            end
            ntab_pkg::MODE_SWEEP: begin
                n_rsp.status = ntab_pkg::ST_SWEPT;
            end
            ntab_pkg::MODE_NTH, ntab_pkg::MODE_FIND: begin
                if (r_hit) begin
                    n_rsp.status               = ntab_pkg::ST_FOUND;
                    n_rsp.found_source_address = r_hit_key[23:16];
                    n_rsp.found_group_number   = r_hit_key[15:0];
                    n_rsp.found_time_ms        = r_hit_time;
                    n_rsp.found_payload        = r_hit_pay;
                end else begin
                    n_rsp.status = ntab_pkg::ST_NOT_FOUND;
                end
            end
            ntab_pkg::MODE_CLEAR: begin
                c_clear          = i_cmd.fin;
                n_rsp.status     = ntab_pkg::ST_CLEARED;
                n_rsp.live_count = '0;
            end
            default: begin
                n_rsp.status = ntab_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    // valid bits and live count
    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        if (e_aged) begin
            n_valid[r_rd_idx] = 1'b0;
            n_count           = r_count - 1'b1;
        end
        if (c_set_valid) begin
            n_valid[c_widx] = 1'b1;
            n_count         = r_count + 1'b1;
        end
        if (c_clear) begin
            n_valid = '0;
            n_count = '0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= ntab_pkg::RESET_TIMEOUT;
            r_valid  <= '0;
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
            r_addr   <= '0;
            r_seen   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_valid  <= n_valid;
            r_count  <= n_count;
            r_rd_vld <= i_cmd.issue;
            r_done   <= i_cmd.fin;
            if (i_cmd.load) begin
                r_hit  <= 1'b0;
                r_free <= 1'b0;
                r_addr <= '0;
                r_seen <= '0;
            end else begin
                if (e_take) begin
                    r_hit <= 1'b1;
                end
                if (e_free) begin
                    r_free <= 1'b1;
                end
                if (i_cmd.issue) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (e_valid) begin
                    r_seen <= r_seen + 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.issue) begin
            r_rd_idx   <= r_addr;
            r_rd_valid <= r_valid[r_addr];
        end
        if (e_take) begin
            r_hit_idx  <= r_rd_idx;
            r_hit_key  <= r_rd_key;
            r_hit_time <= r_rd_time;
            r_hit_pay  <= r_rd_pay;
        end
        if (e_free) begin
            r_free_idx <= r_rd_idx;
        end
        if (i_cmd.fin) begin
            r_rsp <= n_rsp;
        end
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (c_we_key) begin
            mem_key[c_widx] <= {r_req.source_address, r_req.group_number};
        end
        if (c_we_time) begin
            mem_time[c_widx] <= r_req.time_ms;
        end
        if (c_we_pay) begin
            mem_pay[c_widx] <= c_wpay;
        end
        if (i_cmd.issue) begin
            r_rd_key  <= mem_key[r_addr];
            r_rd_time <= mem_time[r_addr];
            r_rd_pay  <= mem_pay[r_addr];
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == ntab_pkg::ST_FULL)) |->
        (o_rsp.live_count == ntab_pkg::CNT_W'(ntab_pkg::SLOTS)))
        else $error("full reported with free slots");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_rsp.status == ntab_pkg::ST_INSERTED)) |->
        (o_rsp.live_count == $past(r_count) + 1'b1))
        else $error("insert did not bump live count");

    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |-> !r_rd_vld)
        else $error("commit with slot read still in flight");

    a_upd_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ((o_rsp.status == ntab_pkg::ST_UPDATED) ||
                    (o_rsp.status == ntab_pkg::ST_INSERTED))) |->
        (o_rsp.found_time_ms == r_req.time_ms))
        else $error("written slot time differs from request");

endmodule

// ----- rtl/node_table_with_aging_top.sv -----
`timescale 1ns / 1ps

// Node table with aging: 32 slots keyed by (source address, group number),
// each holding a last-seen time and an 8-byte payload. A request is taken
// when start is high and busy is low; every request with mode 0 to 4 yields
// exactly one result, shown for one cycle with o_done high. The receiver
// cannot hold results off, so it must take o_rsp whenever o_done is high.
// Modes 5 to 7 are taken and dropped without a result. Update, sweep,
// get-nth and find each scan the whole table through one read port of the
// slot memory, one slot per cycle: a request is accepted, reads all 32
// slots, drains the read stage and writes back, and the result appears in
// the first cycle that busy is low again; a new request may be started in
// that same cycle. Clear skips the scan: it is accepted, then writes back.
// The timeout limit is written through i_cfg_we/i_cfg_wdata; the user must
// write it only while idle, as the block does not enforce this. It resets
// to 5000 ms. Reset empties the table at once (valid bits only).

module node_table_with_aging_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  ntab_pkg::t_req    i_req,
    output logic              o_done,
    output ntab_pkg::t_rsp    o_rsp,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata
);

    ntab_pkg::t_cmd w_cmd;
    ntab_pkg::t_sts w_sts;

    // sequencer: accept, scan, drain, commit
    ntab_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mode  (i_req.mode),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // slot memory, valid bits, scan compare and result register
    ntab_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_req       (i_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_done      (o_done),
        .o_rsp       (o_rsp)
    );

endmodule

// ----- tb/sv/node_table_with_aging_top_tb.sv -----
`timescale 1ns / 1ps

module node_table_with_aging_top_tb;

    import ntab_pkg::*;

    // Modes 5..7 are taken by the block and dropped without a response
    localparam logic [2:0] MODE_RSVD_FIRST = 3'd5;
    localparam logic [2:0] MODE_RSVD_LAST  = 3'd7;

    // Drain allowance: the time of one scanned request, plus margin
    localparam int DRAIN_CYCLES = 40;

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  start       = 1'b0;
    logic  busy;
    t_req  i_req       = '0;
    logic  o_done;
    t_rsp  o_rsp;
    logic  i_cfg_we    = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    node_table_with_aging_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the node table, kept in step with accepted requests
    // ------------------------------------------------------------------
    logic        tbl_valid [SLOTS];
    logic [7:0]  tbl_addr  [SLOTS];
    logic [15:0] tbl_group [SLOTS];
    logic [31:0] tbl_seen  [SLOTS];
    logic [63:0] tbl_data  [SLOTS];
    int unsigned live_slots    = 0;
    logic [31:0] idle_limit_ms = RESET_TIMEOUT;

    // Responses owed by the block, oldest first
    t_rsp table_rsp_q [$];

    int mismatch_count = 0;

    // Sender pacing
    bit          gaps_on    = 1'b1;
    int unsigned burst_left = 0;

    // Stimulus state: notion of "now" and a small key space so that
    // updates hit existing entries and the table actually fills up
    logic [31:0] wall_ms = '0;
    logic [7:0]  addr_pool [6];
    logic [15:0] grp_pool  [6];

    // Apply one accepted request to the shadow table and queue the response
    // it must produce. Reserved modes change nothing and owe nothing.
    task automatic apply_to_table(input t_req r);
        t_rsp        res;
        int          hit;
        int unsigned seen;
        res  = '0;
        hit  = -1;
        seen = 0;
        if (r.mode > MODE_CLEAR) return;
        case (r.mode)
            MODE_UPDATE: begin
                res.status = ST_FULL;
                for (int s = 0; s < SLOTS; s++)
                    if (hit < 0 && tbl_valid[s] && tbl_addr[s] == r.source_address
                        && tbl_group[s] == r.group_number)
                        hit = s;
                if (hit >= 0) begin
                    // refresh: time always, payload only when present
                    tbl_seen[hit] = r.time_ms;
                    if (r.payload_present) tbl_data[hit] = r.payload;
                    res.status = ST_UPDATED;
                end else begin
                    for (int s = 0; s < SLOTS; s++)
                        if (hit < 0 && !tbl_valid[s]) hit = s;
                    if (hit >= 0) begin
                        tbl_valid[hit] = 1'b1;
                        tbl_addr[hit]  = r.source_address;
                        tbl_group[hit] = r.group_number;
                        tbl_seen[hit]  = r.time_ms;
                        tbl_data[hit]  = r.payload_present ? r.payload : 64'd0;
                        live_slots++;
                        res.status = ST_INSERTED;
                    end
                end
            end
            MODE_SWEEP: begin
                // elapsed time wraps modulo 2^32
                for (int s = 0; s < SLOTS; s++)
                    if (tbl_valid[s] && 32'(r.time_ms - tbl_seen[s]) > idle_limit_ms) begin
                        tbl_valid[s] = 1'b0;
                        live_slots--;
                    end
                res.status = ST_SWEPT;
            end
            MODE_NTH: begin
                for (int s = 0; s < SLOTS; s++)
                    if (hit < 0 && tbl_valid[s]) begin
                        if (seen == 32'(r.entry_index)) hit = s;
                        seen++;
                    end
                res.status = (hit >= 0) ? ST_FOUND : ST_NOT_FOUND;
            end
            MODE_FIND: begin
                for (int s = 0; s < SLOTS; s++)
                    if (hit < 0 && tbl_valid[s] && tbl_group[s] == r.group_number) hit = s;
                res.status = (hit >= 0) ? ST_FOUND : ST_NOT_FOUND;
            end
            default: begin
                for (int s = 0; s < SLOTS; s++) tbl_valid[s] = 1'b0;
                live_slots = 0;
                res.status = ST_CLEARED;
            end
        endcase
        // sweep and clear never set hit, so their slot fields stay zero
        if (hit >= 0) begin
            res.found_source_address = tbl_addr[hit];
            res.found_group_number   = tbl_group[hit];
            res.found_time_ms        = tbl_seen[hit];
            res.found_payload        = tbl_data[hit];
        end
        res.live_count = CNT_W'(live_slots);
        table_rsp_q.push_back(res);
    endtask

    // ------------------------------------------------------------------
    // Response checker: o_done marks a one-cycle response, sampled at the
    // rising edge. The block cannot be stalled, so every strobe counts.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n && o_done) begin
            if (table_rsp_q.size() == 0) begin
                $display("%0t ns: response with none pending: expected nothing, actual %p",
                         $time, o_rsp);
                mismatch_count++;
            end else begin
                want = table_rsp_q.pop_front();
                check_field("status",         64'(want.status),   64'(o_rsp.status));
                check_field("source_address", 64'(want.found_source_address),
                            64'(o_rsp.found_source_address));
                check_field("group_number",   64'(want.found_group_number),
                            64'(o_rsp.found_group_number));
                check_field("time_ms",        64'(want.found_time_ms),
                            64'(o_rsp.found_time_ms));
                check_field("payload",        want.found_payload, o_rsp.found_payload);
                check_field("live_count",     64'(want.live_count),
                            64'(o_rsp.live_count));
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driver. Called at a falling edge; returns at a falling edge.
    // start stays high across back-to-back requests inside a burst and is
    // dropped only for a gap, during which the request bus carries junk.
    // ------------------------------------------------------------------
    function automatic t_req junk_req();
        t_req r;
        r.mode            = 3'($urandom);
        r.source_address  = 8'($urandom);
        r.group_number    = 16'($urandom);
        r.time_ms         = $urandom;
        r.payload         = {$urandom, $urandom};
        r.payload_present = 1'($urandom);
        r.entry_index     = NTH_W'($urandom);
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 12);
        return $urandom_range(13, 45);   // long enough to land on any scan phase
    endfunction

    task automatic send_req(input t_req r);
        int unsigned gap;
        start = 1'b1;
        i_req = r;
        // accepted at the first rising edge that sees busy low
        do @(posedge i_clk); while (busy !== 1'b0);
        apply_to_table(r);
        @(negedge i_clk);
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap   = pick_gap();
                start = 1'b0;
                i_req = junk_req();
                repeat (gap) @(negedge i_clk);
                burst_left = $urandom_range(1, 8);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Quiet the bus and let every owed response and any dropped request
    // drain out of the block.
    task automatic wait_idle();
        start = 1'b0;
        while (table_rsp_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_idle_limit(input logic [31:0] limit_ms);
        wait_idle();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = limit_ms;
        @(negedge i_clk);
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = $urandom;
        idle_limit_ms = limit_ms;
    endtask

    // Request of a given mode; fields the mode ignores are random
    function automatic t_req blank_req(input logic [2:0] mode);
        t_req r;
        r      = junk_req();
        r.mode = mode;
        return r;
    endfunction

    function automatic t_req keyed_req(input logic [2:0] mode);
        t_req r;
        r                = blank_req(mode);
        r.source_address = addr_pool[$urandom_range(0, 5)];
        r.group_number   = grp_pool[$urandom_range(0, 5)];
        r.time_ms        = wall_ms;
        return r;
    endfunction

    function automatic t_req upd_req(input logic [7:0] addr, input logic [15:0] grp,
                                     input logic [31:0] t_ms, input logic [63:0] data,
                                     input logic has_data);
        t_req r;
        r                 = blank_req(MODE_UPDATE);
        r.source_address  = addr;
        r.group_number    = grp;
        r.time_ms         = t_ms;
        r.payload         = data;
        r.payload_present = has_data;
        return r;
    endfunction

    function automatic t_req nth_req(input logic [NTH_W-1:0] idx);
        t_req r;
        r             = blank_req(MODE_NTH);
        r.entry_index = idx;
        return r;
    endfunction

    function automatic t_req find_req(input logic [15:0] grp);
        t_req r;
        r              = blank_req(MODE_FIND);
        r.group_number = grp;
        return r;
    endfunction

    function automatic t_req sweep_req(input logic [31:0] now_ms);
        t_req r;
        r         = blank_req(MODE_SWEEP);
        r.time_ms = now_ms;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Lookups, sweep and clear on the empty table right after reset
    task automatic test_empty_table();
        send_req(nth_req('0));
        send_req(find_req(16'h0000));
        send_req(sweep_req(32'hFFFF_FFFF));
        send_req(blank_req(MODE_CLEAR));
    endtask

    // Insert at the field extremes, insert without payload, refresh with and
    // without payload, same address under a second group.
    task automatic test_insert_refresh();
        send_req(upd_req(8'hFF, 16'hFFFF, 32'hFFFF_FFFF, '1, 1'b1));
        send_req(upd_req(8'h00, 16'h0000, 32'd0, 64'hA5A5_5A5A_F00F_0FF0, 1'b0));
        send_req(upd_req(8'hFF, 16'hFFFF, 32'h0000_0010, 64'h1234_5678_9ABC_DEF0, 1'b0));
        send_req(upd_req(8'h00, 16'h0000, 32'd5, '1, 1'b1));
        send_req(upd_req(8'hFF, 16'h0000, 32'hFFFF_F000, 64'h0, 1'b1));
        send_req(upd_req(8'h00, 16'hFFFF, 32'h0000_1000, 64'h8000_0000_0000_0001, 1'b1));
    endtask

    // Nth hit/miss at both ends of the index, find hit and miss
    task automatic test_lookups();
        send_req(nth_req(NTH_W'(0)));
        send_req(nth_req(NTH_W'(3)));
        send_req(nth_req(NTH_W'(4)));
        send_req(nth_req('1));
        send_req(find_req(16'hFFFF));
        send_req(find_req(16'h1234));
    endtask

    // Sweep at 0x800 with the reset limit: the entry stamped just before the
    // wrap is old, the one stamped "in the future" wraps to a huge age.
    // A reserved mode in between must leave no trace.
    task automatic test_sweep_wrap();
        send_req(sweep_req(32'h0000_0800));
        send_req(nth_req(NTH_W'(0)));
        send_req(blank_req(MODE_RSVD_FIRST));
        send_req(nth_req(NTH_W'(1)));
        send_req(blank_req(MODE_CLEAR));
    endtask

    // ------------------------------------------------------------------
    // Random tests
    // ------------------------------------------------------------------

    // Fill to capacity with distinct keys, overflow, refresh while full,
    // then probe the last ordinal and groups in and out of the table.
    task automatic test_table_full();
        logic [15:0] grp_of [SLOTS + 4];
        int unsigned pick;
        for (int round = 0; round < 3; round++) begin
            gaps_on = (round != 1);   // middle round runs back to back
            send_req(blank_req(MODE_CLEAR));
            for (int k = 0; k < SLOTS + 4; k++) begin
                grp_of[k] = 16'($urandom);
                send_req(upd_req(8'(k + 64 * round), grp_of[k], $urandom,
                                 {$urandom, $urandom}, 1'($urandom)));
            end
            pick = $urandom_range(0, SLOTS - 1);
            send_req(upd_req(8'(pick + 64 * round), grp_of[pick], $urandom,
                             {$urandom, $urandom}, 1'($urandom)));
            send_req(nth_req(NTH_W'(SLOTS - 1)));
            send_req(nth_req(NTH_W'($urandom)));
            send_req(find_req(grp_of[$urandom_range(0, SLOTS - 1)]));
            send_req(find_req(grp_of[SLOTS + 1]));
        end
        gaps_on = 1'b1;
    endtask

    // Aging under several limits, the extremes among them. Each phase walks
    // the clock forward by steps on the scale of the limit and checks the
    // boundary: age equal to the limit stays, one more is freed.
    task automatic test_aging();
        logic [31:0] limits [5];
        logic [31:0] span;
        logic [31:0] stamp;
        int unsigned roll;
        limits[0] = 32'd0;
        limits[1] = 32'hFFFF_FFFF;
        limits[2] = 32'd1;
        limits[3] = $urandom_range(2, 200000);
        limits[4] = RESET_TIMEOUT;
        foreach (limits[p]) begin
            set_idle_limit(limits[p]);
            span = (limits[p] == 0) ? 32'd3 :
                   (limits[p] > 32'd1_000_000) ? 32'hFFFF_FFFF : limits[p] / 4 + 1;
            send_req(blank_req(MODE_CLEAR));
            stamp = wall_ms;
            send_req(upd_req(addr_pool[0], grp_pool[0], stamp, {$urandom, $urandom}, 1'b1));
            send_req(sweep_req(stamp + limits[p]));
            send_req(sweep_req(stamp + limits[p] + 1));
            for (int n = 0; n < 56; n++) begin
                wall_ms += $urandom_range(0, span);
                roll = $urandom_range(0, 99);
                if (roll < 60)      send_req(keyed_req(MODE_UPDATE));
                else if (roll < 80) send_req(sweep_req(wall_ms));
                else if (roll < 90) send_req(keyed_req(MODE_NTH));
                else                send_req(keyed_req(MODE_FIND));
            end
        end
    endtask

    // Mixed traffic over the small key space, with broken/noise requests:
    // fully random fields and reserved modes.
    task automatic test_mixed_traffic();
        t_req        r;
        int unsigned roll;
        set_idle_limit(32'd20000);
        for (int n = 0; n < 720; n++) begin
            // a stretch with no sender gaps in the middle of the run
            gaps_on = !(n >= 300 && n < 360);
            wall_ms += $urandom_range(0, 6000);
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                r = junk_req();
            end else if (roll < 8) begin
                r      = junk_req();
                r.mode = 3'($urandom_range(MODE_RSVD_FIRST, MODE_RSVD_LAST));
            end else if (roll < 56) begin
                r = keyed_req(MODE_UPDATE);
            end else if (roll < 64) begin
                r = sweep_req(wall_ms);
            end else if (roll < 80) begin
                r = keyed_req(MODE_NTH);
                r.entry_index = NTH_W'($urandom_range(0, live_slots + 1));
            end else if (roll < 98) begin
                r = keyed_req(MODE_FIND);
            end else begin
                r = blank_req(MODE_CLEAR);
            end
            send_req(r);
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        foreach (tbl_valid[s]) begin
            tbl_valid[s] = 1'b0;
            tbl_addr[s]  = '0;
            tbl_group[s] = '0;
            tbl_seen[s]  = '0;
            tbl_data[s]  = '0;
        end
        addr_pool = '{8'h00, 8'h01, 8'h02, 8'h80, 8'hFE, 8'hFF};
        grp_pool  = '{16'h0000, 16'h0001, 16'hFFFF, 16'($urandom), 16'($urandom),
                      16'($urandom)};
        wall_ms   = $urandom;

        // synchronous reset, released at a falling edge
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_insert_refresh();
        test_lookups();
        test_sweep_wrap();
        test_table_full();
        test_aging();
        test_mixed_traffic();

        wait_idle();
        if (mismatch_count == 0 && table_rsp_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
